/* rtl/cfp_pkg.sv */
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants of the command frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

   localparam int unsigned WIN_DEPTH       = 11;
   localparam int unsigned CSR_INDEX_WIDTH = 8;

   localparam logic [7:0] TYPE_VEL  = 8'h05;
   localparam logic [7:0] TYPE_GAIN = 8'h06;
   localparam logic [7:0] TAIL_BYTE = 8'had;

   localparam logic [7:0] HEADER_FIRST_RESET  = 8'hce;
   localparam logic [7:0] HEADER_SECOND_RESET = 8'hfa;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_FIRST  = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_SECOND = CSR_INDEX_WIDTH'(1);

   localparam logic KIND_VEL  = 1'b0;
   localparam logic KIND_GAIN = 1'b1;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } cell_state_type;

   typedef struct packed {
      logic               frame_kind;
      logic signed [15:0] value_first;
      logic signed [15:0] value_second;
      logic        [15:0] value_third;
   } result_type;

endpackage

/* rtl/cfp_if.sv */
// ----------------------------------------------------------------------------
// cfp_if
// Request, response and register write channels of the frame parser.
// ----------------------------------------------------------------------------
interface cfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       block_end;

   modport source (output valid, output rx_byte, output block_end, input ready);
   modport sink   (input valid, input rx_byte, input block_end, output ready);
endinterface

interface cfp_rsp_if;
   logic               valid;
   logic               ready;
   logic               frame_kind;
   logic signed [15:0] value_first;
   logic signed [15:0] value_second;
   logic        [15:0] value_third;

   modport source (output valid, output frame_kind, output value_first,
                   output value_second, output value_third, input ready);
   modport sink   (input valid, input frame_kind, input value_first,
                   input value_second, input value_third, output ready);
endinterface

interface cfp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/cfp_cell.sv */
// ----------------------------------------------------------------------------
// cfp_cell
// One window cell: holds a byte and its valid mark, takes its neighbor's
// content on each accepted request and clears at the end of a block.
// ----------------------------------------------------------------------------
module cfp_cell
   import cfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           shift_en,
   input  logic           clear,
   input  cell_state_type cell_in,
   output cell_state_type cell_out
);

   cell_state_type cell_ff;
   cell_state_type cell_nx_in;

   always_comb begin
      cell_nx_in = cell_ff;
      if (shift_en) begin
         if (clear) begin
            cell_nx_in = '0;
         end else begin
            cell_nx_in = cell_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_nx_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

/* rtl/command_frame_parser_core.sv */
// ----------------------------------------------------------------------------
// command_frame_parser_core
// Finds velocity and gain command frames in a received byte stream using a
// chain of byte cells and reports their raw scaled values.
//
//   channel | dir | payload                                       | handshake
//   req     | in  | rx_byte, block_end                            | valid/ready
//   rsp     | out | frame_kind, value_first/second/third          | valid/ready
//   csr     | in  | index, data                                   | valid/ready
//
// One request per cycle; a result appears in the cycle after the request that
// completes a frame. Throughput is set by the single response register, which
// a downstream stall backs into req.ready. Reset clears the window, the valid
// marks and loads the default header bytes. Register writes are always ready.
// ----------------------------------------------------------------------------
module command_frame_parser_core
   import cfp_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   cfp_req_if.sink   req,
   cfp_rsp_if.source rsp,
   cfp_csr_if.sink   csr
);

   logic [7:0] header_first_ff;
   logic [7:0] header_second_ff;

   cell_state_type cell_in  [WIN_DEPTH];
   cell_state_type cell_q   [WIN_DEPTH];
   logic [WIN_DEPTH-1:0] valid_vec;

   logic       req_fire;
   logic       gain_hit;
   logic       vel_hit;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type rsp_in;

   assign req_fire  = req.valid && req.ready;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= HEADER_FIRST_RESET;
         header_second_ff <= HEADER_SECOND_RESET;
      end else if (csr.valid && csr.ready) begin
         case (csr.index)
            CSR_HEADER_FIRST:  header_first_ff  <= csr.data;
            CSR_HEADER_SECOND: header_second_ff <= csr.data;
            default: ;
         endcase
      end
   end

   assign cell_in[0] = '{valid: 1'b1, data: req.rx_byte};

   for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
      if (k > 0) begin : g_link
         assign cell_in[k] = cell_q[k-1];
      end
      cfp_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (req_fire),
         .clear    (req.block_end),
         .cell_in  (cell_in[k]),
         .cell_out (cell_q[k])
      );
      assign valid_vec[k] = cell_q[k].valid;
   end

   // window after this byte: position p holds cell p-1, position 0 the new byte
   assign gain_hit = cell_q[9].valid
                     && cell_q[9].data == header_first_ff
                     && cell_q[8].data == header_second_ff
                     && cell_q[7].data == TYPE_GAIN
                     && req.rx_byte == TAIL_BYTE;

   assign vel_hit  = cell_q[7].valid
                     && cell_q[7].data == header_first_ff
                     && cell_q[6].data == header_second_ff
                     && cell_q[5].data == TYPE_VEL
                     && req.rx_byte == TAIL_BYTE;

   always_comb begin
      rsp_in = rsp_ff;
      if (gain_hit) begin
         rsp_in.frame_kind   = KIND_GAIN;
         rsp_in.value_first  = {cell_q[4].data, cell_q[5].data};
         rsp_in.value_second = {cell_q[2].data, cell_q[3].data};
         rsp_in.value_third  = {cell_q[0].data, cell_q[1].data};
      end else begin
         rsp_in.frame_kind   = KIND_VEL;
         rsp_in.value_first  = {cell_q[2].data, cell_q[3].data};
         rsp_in.value_second = {cell_q[0].data, cell_q[1].data};
         rsp_in.value_third  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req.ready) begin
         rsp_valid_ff <= req.valid && (gain_hit || vel_hit);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (gain_hit || vel_hit)) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.frame_kind   = rsp_ff.frame_kind;
   assign rsp.value_first  = rsp_ff.value_first;
   assign rsp.value_second = rsp_ff.value_second;
   assign rsp.value_third  = rsp_ff.value_third;

`ifndef SYNTHESIS
   a_hit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (gain_hit || vel_hit)) |=> rsp.valid)
      else $error("frame hit did not raise a response");

   a_block_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.block_end) |=> ($countones(valid_vec) == 0))
      else $error("window not cleared after block end");

   a_valid_thermometer: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec & ~{valid_vec[WIN_DEPTH-2:0], 1'b1}) == '0))
      else $error("window valid marks not contiguous");

   a_no_rsp_without_req: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !req_fire) |=> !rsp.valid)
      else $error("response raised without a request");
`endif

endmodule

/* tb/cfp_frame_checker.sv */
// ----------------------------------------------------------------------------
// cfp_frame_checker
// Watches the request, response and register write channels of the frame
// parser. It keeps its own byte window and header registers, works out the
// frame that each accepted request completes, and compares every accepted
// response field by field with the oldest outstanding frame.
// ----------------------------------------------------------------------------
module cfp_frame_checker
   import cfp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   cfp_req_if   req_mon,
   cfp_rsp_if   rsp_mon,
   cfp_csr_if   csr_mon,
   output int   fail_count,
   output int   pending
);

   localparam int unsigned VEL_FRAME_BYTES  = 9;
   localparam int unsigned GAIN_FRAME_BYTES = 11;

   logic [7:0]  hdr_first;
   logic [7:0]  hdr_second;
   logic [7:0]  window [WIN_DEPTH];
   int unsigned fill;
   result_type  decoded_frames [$];
   int          errors = 0;

   function automatic void clear_window();
      foreach (window[k]) window[k] = 8'h00;
      fill = 0;
   endfunction

   function automatic void decode_byte(input logic [7:0] rx, input logic last);
      result_type frame;
      for (int k = WIN_DEPTH - 1; k > 0; k--) window[k] = window[k - 1];
      window[0] = rx;
      if (fill < WIN_DEPTH) fill++;
      if (fill >= GAIN_FRAME_BYTES && window[10] == hdr_first &&
          window[9] == hdr_second && window[8] == TYPE_GAIN &&
          window[0] == TAIL_BYTE) begin
         frame.frame_kind   = KIND_GAIN;
         frame.value_first  = {window[5], window[6]};
         frame.value_second = {window[3], window[4]};
         frame.value_third  = {window[1], window[2]};
         decoded_frames.push_back(frame);
      end else if (fill >= VEL_FRAME_BYTES && window[8] == hdr_first &&
                   window[7] == hdr_second && window[6] == TYPE_VEL &&
                   window[0] == TAIL_BYTE) begin
         frame.frame_kind   = KIND_VEL;
         frame.value_first  = {window[3], window[4]};
         frame.value_second = {window[1], window[2]};
         frame.value_third  = 16'h0000;
         decoded_frames.push_back(frame);
      end
      if (last) clear_window();
   endfunction

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   function automatic void check_frame();
      result_type want;
      if (decoded_frames.size() == 0) begin
         $display("%0t unexpected frame: expected none, actual kind %0d values %h %h %h",
                  $time, rsp_mon.frame_kind, rsp_mon.value_first, rsp_mon.value_second,
                  rsp_mon.value_third);
         errors++;
      end else begin
         want = decoded_frames.pop_front();
         compare_field("frame_kind", 16'(want.frame_kind), 16'(rsp_mon.frame_kind));
         compare_field("value_first", want.value_first, rsp_mon.value_first);
         compare_field("value_second", want.value_second, rsp_mon.value_second);
         compare_field("value_third", want.value_third, rsp_mon.value_third);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         hdr_first  = HEADER_FIRST_RESET;
         hdr_second = HEADER_SECOND_RESET;
         clear_window();
         decoded_frames.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_HEADER_FIRST) hdr_first = csr_mon.data;
            else if (csr_mon.index == CSR_HEADER_SECOND) hdr_second = csr_mon.data;
         end
         if (rsp_mon.valid && rsp_mon.ready) check_frame();
         if (req_mon.valid && req_mon.ready) decode_byte(req_mon.rx_byte, req_mon.block_end);
      end
      pending    <= decoded_frames.size();
      fail_count <= errors;
   end

endmodule

/* tb/command_frame_parser_core_tb.sv */
// ----------------------------------------------------------------------------
// command_frame_parser_core_tb
// Drives byte requests, header register writes and response back-pressure
// into the command frame parser. A short directed run covers extreme values
// and block boundaries, then phases with different header settings send
// mostly well-formed frames with random content, mixed with corrupted frames
// and noise. Checking is done by cfp_frame_checker.
// ----------------------------------------------------------------------------
module command_frame_parser_core_tb
   import cfp_pkg::*;
();

   localparam int         CYCLE_LIMIT = 100000;
   localparam int         HOLD_CYCLES = 300;
   localparam int         NUM_PHASES  = 6;
   localparam int         PHASE_ITEMS = 120;
   localparam logic [7:0] CSR_LAST    = 8'hff;
   localparam logic [7:0] TYPE_OTHER  = 8'h07;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cfp_req_if req ();
   cfp_rsp_if rsp ();
   cfp_csr_if csr ();

   int         fail_count;
   int         pending;
   int         cycles = 0;
   int         sent_items = 0;
   int         hold_kicks = 0;
   logic       idle_on = 1'b1;
   logic [7:0] cur_first = HEADER_FIRST_RESET;
   logic [7:0] cur_second = HEADER_SECOND_RESET;
   logic [7:0] frame_bytes [$];

   command_frame_parser_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   cfp_frame_checker frame_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req),
      .rsp_mon    (rsp),
      .csr_mon    (csr),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin : receiver
      int kicks_seen;
      int hold_left;
      kicks_seen = 0;
      hold_left  = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_kicks != kicks_seen) begin
            kicks_seen = hold_kicks;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else if (idle_on) begin
            rsp.ready <= ($urandom_range(99) >= 33);
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   function automatic logic [7:0] length_byte(input logic [7:0] good);
      return ($urandom_range(9) < 7) ? good : 8'($urandom);
   endfunction

   function automatic void push_velocity(input logic [15:0] lin, input logic [15:0] ang,
                                         input logic [7:0] len);
      frame_bytes.push_back(cur_first);
      frame_bytes.push_back(cur_second);
      frame_bytes.push_back(TYPE_VEL);
      frame_bytes.push_back(len);
      frame_bytes.push_back(lin[7:0]);
      frame_bytes.push_back(lin[15:8]);
      frame_bytes.push_back(ang[7:0]);
      frame_bytes.push_back(ang[15:8]);
      frame_bytes.push_back(TAIL_BYTE);
   endfunction

   function automatic void push_gain(input logic [15:0] kp, input logic [15:0] ki,
                                     input logic [15:0] kd, input logic [7:0] len);
      frame_bytes.push_back(cur_first);
      frame_bytes.push_back(cur_second);
      frame_bytes.push_back(TYPE_GAIN);
      frame_bytes.push_back(len);
      frame_bytes.push_back(kp[7:0]);
      frame_bytes.push_back(kp[15:8]);
      frame_bytes.push_back(ki[7:0]);
      frame_bytes.push_back(ki[15:8]);
      frame_bytes.push_back(kd[7:0]);
      frame_bytes.push_back(kd[15:8]);
      frame_bytes.push_back(TAIL_BYTE);
   endfunction

   task automatic send_byte(input logic [7:0] rx, input logic last);
      while (idle_on && $urandom_range(99) < 33) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.rx_byte   <= rx;
      req.block_end <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent_items++;
   endtask

   task automatic send_burst(input int cut);
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == cut);
      frame_bytes.delete();
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      if (idx == CSR_HEADER_FIRST) cur_first = value;
      else if (idx == CSR_HEADER_SECOND) cur_second = value;
   endtask

   task automatic random_chunk();
      int choice;
      int lead;
      int pos;
      int cut;
      choice = $urandom_range(99);
      lead   = $urandom_range(3);
      cut    = -1;
      repeat (lead) frame_bytes.push_back(8'($urandom));
      if (choice < 70) begin
         if ($urandom_range(1))
            push_gain(16'($urandom), 16'($urandom), 16'($urandom), length_byte(8'd6));
         else
            push_velocity(16'($urandom), 16'($urandom), length_byte(8'd4));
         if (choice >= 58) begin
            case ($urandom_range(3))
               0: begin
                  pos = lead + $urandom_range(2);
                  frame_bytes[pos] ^= 8'($urandom_range(1, 255));
               end
               1: frame_bytes[frame_bytes.size() - 1] ^= 8'($urandom_range(1, 255));
               default: cut = $urandom_range(lead, frame_bytes.size() - 2);
            endcase
         end else if ($urandom_range(3) == 0) begin
            cut = frame_bytes.size() - 1;
         end
      end else begin
         repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
         if ($urandom_range(4) == 0) cut = frame_bytes.size() - 1;
      end
      send_burst(cut);
   endtask

   initial begin : stimulus
      logic [7:0] first_set  [NUM_PHASES];
      logic [7:0] second_set [NUM_PHASES];
      int         phase_end;
      first_set  = '{8'h00, 8'hff, 8'h06, HEADER_FIRST_RESET, 8'($urandom), 8'($urandom)};
      second_set = '{8'h00, 8'hff, 8'($urandom), HEADER_SECOND_RESET, 8'($urandom),
                     8'($urandom)};
      req.valid     <= 1'b0;
      req.rx_byte   <= 8'h00;
      req.block_end <= 1'b0;
      csr.valid     <= 1'b0;
      csr.index     <= CSR_HEADER_FIRST;
      csr.data      <= 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      push_gain(16'h8000, 16'h7fff, 16'hffff, 8'd6);
      send_burst(10);
      push_velocity(16'h0000, 16'hffff, 8'h00);
      send_burst(-1);
      push_velocity(16'h1234, 16'h5678, 8'd4);
      frame_bytes[2] = TYPE_OTHER;
      send_burst(3);

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         write_reg(CSR_HEADER_FIRST, first_set[p]);
         write_reg(CSR_HEADER_SECOND, second_set[p]);
         write_reg((p == 0) ? CSR_LAST : 8'($urandom_range(2, 255)), 8'($urandom));
         csr.valid <= 1'b0;
         idle_on   <= (p != 1);
         if (p == 0) begin
            send_byte(8'($urandom), 1'b1);
            frame_bytes = '{TYPE_VEL, 8'd4, 8'h01, 8'h02, 8'h03, 8'h04, TAIL_BYTE};
            send_burst(-1);
         end
         if (p == 2) begin
            push_gain({8'($urandom), TYPE_VEL}, 16'($urandom), 16'($urandom), cur_second);
            send_burst(-1);
            hold_kicks <= hold_kicks + 1;
         end
         phase_end = 29 + (p + 1) * PHASE_ITEMS;
         while (sent_items < phase_end) random_chunk();
      end

      drain();
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
